// ----- src/matrix_vector_multiply_defines.svh -----
// Assertion macros shared by the checker of the matrix-vector multiplier.
// No dependencies; pulled in with `include by the files that assert.
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MVM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MVM_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/mvm_pkg.sv -----
// Shared types and constants of the matrix-vector multiplier.
// No dependencies; imported by the MAC unit, the top level, the checker and the bench.
package mvm_pkg;

   localparam int VAL_W   = 16;   // Q8.8 weights and vector elements
   localparam int PROD_W  = 32;   // Q16.16 product
   localparam int SUM_W   = 32;   // saturated Q16.16 result
   localparam int ACC_W   = 38;   // 64 products summed exactly
   localparam int CNT_W   = 7;    // row and column counts, 1..64
   localparam int IDX_W   = 6;    // row and column indexes
   localparam int CSR_IDX_W = 1;

   localparam logic ACT_WEIGHT = 1'b0;
   localparam logic ACT_VECTOR = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = 1'b1;

   localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

   typedef struct packed {
      logic valid;
      logic first;   // first column of a row: restart the accumulator
      logic last;    // last column of a row: sum is complete after it
   } mac_ctl_type;

endpackage

// ----- src/mvm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the weight and vector stores.
module mvm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mvm_mac.sv -----
// Shared multiply-accumulate unit: registered product, exact accumulator,
// saturation to 32 bits. Depends on mvm_pkg.
module mvm_mac
   import mvm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctl_type             ctl,
   input  logic signed [VAL_W-1:0] weight,
   input  logic signed [VAL_W-1:0] element,
   input  logic                    take,
   output logic                    sum_valid,
   output logic signed [SUM_W-1:0] sum
);

   mac_ctl_type              ctl2_ff, ctl2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     sum_valid_ff, sum_valid_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic                     fits;

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      ctl2_in      = ctl;
      prod_in      = weight * element;
      acc_in       = acc_ff;
      sum_valid_in = sum_valid_ff;
      if (ctl2_ff.valid) begin
         acc_in = (ctl2_ff.first ? '0 : acc_ff) + prod_ext;
      end
      if (ctl2_ff.valid && ctl2_ff.last) begin
         sum_valid_in = 1'b1;
      end else if (take) begin
         sum_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff      <= '0;
         prod_ff      <= '0;
         acc_ff       <= '0;
         sum_valid_ff <= 1'b0;
      end else begin
         ctl2_ff      <= ctl2_in;
         prod_ff      <= prod_in;
         acc_ff       <= acc_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

   // in range when every bit above the 32-bit sign equals it
   assign fits = (acc_ff[ACC_W-1:SUM_W-1] == '0) || (acc_ff[ACC_W-1:SUM_W-1] == '1);

   always_comb begin
      if (fits) begin
         sum = acc_ff[SUM_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sum = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(SUM_W-1){1'b1}}};
      end
   end

   assign sum_valid = sum_valid_ff;

endmodule

// ----- src/matrix_vector_multiply.sv -----
// Matrix-vector multiplier, top level: sequencer, weight and vector RAMs,
// one shared MAC, result register. Depends on mvm_pkg, mvm_ram, mvm_mac.
//
// Usage:
//   req_* carries one transaction: a weight write (action 0, row_sel,
//   col_sel, value) or a vector element (action 1, col_sel, value).
//   The element for the last used column starts a run that returns one
//   rsp_* transaction per used row, in row order, rsp_last on the final.
//   csr_* writes rows_used (index 0) and cols_used (index 1); csr_ready is
//   always high.
// Sequencing:
//   Weight writes and non-triggering elements leave the sequencer idle.
//   A triggering element holds req_ready low until the final row's sum is
//   loaded into the result register: every row issues one MAC operation
//   per column through the single multiplier, then passes RAM read,
//   product and accumulate before its sum lands in the result register.
// Reset: counts return to 64, no result pending; RAMs keep their contents.
// Stalls: a held result stalls the sequencer before the next row's sum is
//   loaded; nothing is dropped. req_ready may be high while the final
//   result still waits to be taken.
module matrix_vector_multiply
   import mvm_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic [IDX_W-1:0]        req_row_sel,
   input  logic [IDX_W-1:0]        req_col_sel,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_out_row,
   output logic signed [SUM_W-1:0] rsp_dot_sum,
   output logic                    rsp_last,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CNT_W-1:0]        csr_wdata
);

   localparam int W_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int WAW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int VAW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_CAP = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int COL_CAP = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam logic [WAW-1:0] ROW_STRIDE = WAW'(MAX_COLS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     row_ff, row_in;
   logic [IDX_W-1:0]     col_ff, col_in;
   logic [WAW-1:0]       wbase_ff, wbase_in;
   logic [CNT_W-1:0]     nrows_ff, nrows_in;
   logic [CNT_W-1:0]     ncols_ff, ncols_in;
   logic [CNT_W-1:0]     rows_cfg_ff, rows_cfg_in;
   logic [CNT_W-1:0]     cols_cfg_ff, cols_cfg_in;
   mac_ctl_type          ctl1_ff, ctl1_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_row_ff, rsp_row_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]     nrows_eff, ncols_eff;
   logic                 w_we, v_we, take;
   logic [WAW-1:0]       w_waddr, w_raddr;
   logic [VAW-1:0]       v_waddr, v_raddr;
   logic [VAL_W-1:0]     w_rdata, v_rdata;
   logic                 mac_sum_valid;
   logic signed [SUM_W-1:0] mac_sum;
   logic                 row_ok, col_ok, row_done;

   // effective counts clamped to 1..cap
   always_comb begin
      if (rows_cfg_ff == '0) begin
         nrows_eff = 7'd1;
      end else if (rows_cfg_ff > CNT_W'(ROW_CAP)) begin
         nrows_eff = CNT_W'(ROW_CAP);
      end else begin
         nrows_eff = rows_cfg_ff;
      end
      if (cols_cfg_ff == '0) begin
         ncols_eff = 7'd1;
      end else if (cols_cfg_ff > CNT_W'(COL_CAP)) begin
         ncols_eff = CNT_W'(COL_CAP);
      end else begin
         ncols_eff = cols_cfg_ff;
      end
   end

   assign row_ok   = 9'(req_row_sel) < 9'(MAX_ROWS);
   assign col_ok   = 9'(req_col_sel) < 9'(MAX_COLS);
   assign row_done = ({1'b0, row_ff} == nrows_ff - 7'd1);

   assign w_waddr = WAW'(req_row_sel) * ROW_STRIDE + WAW'(req_col_sel);
   assign v_waddr = VAW'(req_col_sel);
   assign w_raddr = wbase_ff + WAW'(col_ff);
   assign v_raddr = VAW'(col_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wbase_in     = wbase_ff;
      nrows_in     = nrows_ff;
      ncols_in     = ncols_ff;
      rows_cfg_in  = rows_cfg_ff;
      cols_cfg_in  = cols_cfg_ff;
      ctl1_in      = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_last_in  = rsp_last_ff;
      w_we         = 1'b0;
      v_we         = 1'b0;
      take         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         if (csr_index == CSR_ROWS_USED) begin
            rows_cfg_in = csr_wdata;
         end else begin
            cols_cfg_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_WEIGHT) begin
                  w_we = row_ok && col_ok;
               end else if (col_ok) begin
                  v_we = 1'b1;
                  if ({1'b0, req_col_sel} == ncols_eff - 7'd1) begin
                     state_in = ST_ISSUE;
                     row_in   = '0;
                     col_in   = '0;
                     wbase_in = '0;
                     nrows_in = nrows_eff;
                     ncols_in = ncols_eff;
                  end
               end
            end
         end
         ST_ISSUE: begin
            ctl1_in.valid = 1'b1;
            ctl1_in.first = (col_ff == '0);
            ctl1_in.last  = ({1'b0, col_ff} == ncols_ff - 7'd1);
            if (ctl1_in.last) begin
               state_in = ST_WAIT;
            end else begin
               col_in = col_ff + 6'd1;
            end
         end
         ST_WAIT: begin
            if (mac_sum_valid && (!rsp_valid_ff || rsp_ready)) begin
               take         = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_sum_in   = mac_sum;
               rsp_last_in  = row_done;
               if (row_done) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  row_in   = row_ff + 6'd1;
                  col_in   = '0;
                  wbase_in = wbase_ff + ROW_STRIDE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         wbase_ff     <= '0;
         nrows_ff     <= CNT_RESET;
         ncols_ff     <= CNT_RESET;
         rows_cfg_ff  <= CNT_RESET;
         cols_cfg_ff  <= CNT_RESET;
         ctl1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_row_ff   <= '0;
         rsp_sum_ff   <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         wbase_ff     <= wbase_in;
         nrows_ff     <= nrows_in;
         ncols_ff     <= ncols_in;
         rows_cfg_ff  <= rows_cfg_in;
         cols_cfg_ff  <= cols_cfg_in;
         ctl1_ff      <= ctl1_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_sum_ff   <= rsp_sum_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   mvm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (W_DEPTH),
      .ADDR_W(WAW)
   ) u_weight_ram (
      .clock  (clock),
      .wr_en  (w_we),
      .wr_addr(w_waddr),
      .wr_data(req_value),
      .rd_addr(w_raddr),
      .rd_data(w_rdata)
   );

   mvm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_COLS),
      .ADDR_W(VAW)
   ) u_vector_ram (
      .clock  (clock),
      .wr_en  (v_we),
      .wr_addr(v_waddr),
      .wr_data(req_value),
      .rd_addr(v_raddr),
      .rd_data(v_rdata)
   );

   mvm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl1_ff),
      .weight   (w_rdata),
      .element  (v_rdata),
      .take     (take),
      .sum_valid(mac_sum_valid),
      .sum      (mac_sum)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_dot_sum = rsp_sum_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

// ----- src/mvm_checker.sv -----
// Port-level checker for the matrix-vector multiplier, bound to the top.
// Depends on mvm_pkg and matrix_vector_multiply_defines.svh.
`include "matrix_vector_multiply_defines.svh"

module mvm_checker
   import mvm_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    req_action,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [IDX_W-1:0]        rsp_out_row,
   input logic signed [SUM_W-1:0] rsp_dot_sum,
   input logic                    rsp_last
);

   // a stalled result keeps its payload
   `MVM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dot_sum) && $stable(rsp_out_row) && $stable(rsp_last), "result changed while stalled")

   // while a non-final row result is out, the run is still going
   `MVM_ASSERT(a_run_busy, clock, reset, rsp_valid && !rsp_last |-> !req_ready, "input accepted in the middle of a run")

   // a weight write never starts a run
   `MVM_ASSERT(a_weight_idle, clock, reset, req_valid && req_ready && (req_action == ACT_WEIGHT) |=> req_ready, "weight write left the sequencer busy")

   // reset leaves no result pending
   `MVM_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid, "result pending after reset")

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (.*);

// ----- bench/matrix_vector_multiply_test.sv -----
// Self-checking bench for matrix_vector_multiply: directed table, then random phases per size.
// Depends on mvm_pkg and the matrix_vector_multiply RTL; predicts every row sum itself.
module matrix_vector_multiply_test;
   import mvm_pkg::*;

   localparam int ROW_CAP = 64;
   localparam int COL_CAP = 64;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 50;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   // random phases: register values (out-of-range ones included) and item counts
   localparam int NUM_PHASES = 12;
   localparam logic [CNT_W-1:0] PHASE_ROWS [NUM_PHASES] =
      '{7'd3, 7'd1, 7'd8, 7'd0, 7'd2, 7'd5, 7'd64, 7'd100, 7'd6, 7'd127, 7'd7, 7'd1};
   localparam logic [CNT_W-1:0] PHASE_COLS [NUM_PHASES] =
      '{7'd4, 7'd1, 7'd2, 7'd5, 7'd0, 7'd8, 7'd1, 7'd1, 7'd6, 7'd0, 7'd3, 7'd7};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{20, 10, 12, 12, 10, 16, 6, 4, 16, 4, 12, 16};

   typedef struct packed {
      logic [IDX_W-1:0]        row;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } dot_result_type;

   typedef enum logic {STEP_CSR, STEP_REQ} step_kind_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [CSR_IDX_W-1:0]   csr_idx;
      logic [CNT_W-1:0]       csr_data;
      logic                   act;
      logic [IDX_W-1:0]       row;
      logic [IDX_W-1:0]       col;
      logic [VAL_W-1:0]       val;
      bit                     typed;
      logic [SUM_W-1:0]       want;
   } step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_action = ACT_WEIGHT;
   logic [IDX_W-1:0]        req_row_sel = '0;
   logic [IDX_W-1:0]        req_col_sel = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [IDX_W-1:0]        rsp_out_row;
   logic signed [SUM_W-1:0] rsp_dot_sum;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_ROWS_USED;
   logic [CNT_W-1:0]        csr_wdata = '0;

   // bench copy of the block state
   logic signed [VAL_W-1:0] weight_mem [ROW_CAP][COL_CAP];
   logic signed [VAL_W-1:0] vector_mem [COL_CAP];
   bit                      weight_set [ROW_CAP][COL_CAP];
   bit                      vector_set [COL_CAP];
   logic [CNT_W-1:0]        rows_cfg = CNT_RESET;
   logic [CNT_W-1:0]        cols_cfg = CNT_RESET;

   dot_result_type pending_dots[$];
   step_type       directed[$];
   int             fail_count = 0;
   bit             no_idle = 1'b0;

   matrix_vector_multiply u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_row_sel (req_row_sel),
      .req_col_sel (req_col_sel),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_row (rsp_out_row),
      .rsp_dot_sum (rsp_dot_sum),
      .rsp_last    (rsp_last),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 36);
   end

   function automatic int eff_count(input logic [CNT_W-1:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return int'(v);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic step_type csr_step(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CNT_W-1:0] data);
      step_type s;
      s = '0;
      s.kind = STEP_CSR;
      s.csr_idx = idx;
      s.csr_data = data;
      return s;
   endfunction

   function automatic step_type req_step(input logic act, input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [VAL_W-1:0] val,
                                         input bit typed = 1'b0,
                                         input logic [SUM_W-1:0] want = '0);
      step_type s;
      s = '0;
      s.kind = STEP_REQ;
      s.act = act;
      s.row = row;
      s.col = col;
      s.val = val;
      s.typed = typed;
      s.want = want;
      return s;
   endfunction

   function automatic void add_step(input step_type s);
      directed.insert(directed.size(), s);
   endfunction

   // Updates the stores; the last used column's element queues one sum per used row.
   // A typed sum replaces the computed one for every row; the table types only single-row runs.
   task automatic predict_dot_products(input logic act, input logic [IDX_W-1:0] row,
                                       input logic [IDX_W-1:0] col,
                                       input logic [VAL_W-1:0] val,
                                       input bit typed, input logic [SUM_W-1:0] want);
      int nr;
      int nc;
      longint acc;
      dot_result_type res;
      nr = eff_count(rows_cfg);
      nc = eff_count(cols_cfg);
      if (act == ACT_WEIGHT) begin
         weight_mem[row][col] = val;
         weight_set[row][col] = 1'b1;
      end else begin
         vector_mem[col] = val;
         vector_set[col] = 1'b1;
         if (int'(col) == nc - 1) begin
            for (int r = 0; r < nr; r++) begin
               acc = 0;
               for (int c = 0; c < nc; c++)
                  acc += longint'(weight_mem[r][c]) * longint'(vector_mem[c]);
               if (acc > SUM_MAX) acc = SUM_MAX;
               else if (acc < SUM_MIN) acc = SUM_MIN;
               res.row = IDX_W'(r);
               res.sum = typed ? want : acc[SUM_W-1:0];
               res.last = (r == nr - 1);
               pending_dots.insert(pending_dots.size(), res);
            end
         end
      end
   endtask

   task automatic send_req(input logic act, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] val,
                           input bit typed = 1'b0, input logic [SUM_W-1:0] want = '0);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_row_sel <= row;
      req_col_sel <= col;
      req_value   <= val;
      do @(posedge clock); while (!req_ready);
      predict_dot_products(act, row, col, val, typed, want);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Only while idle: every queued sum taken, then a settling wait for trailing writes.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
      release_req();
      while (pending_dots.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ROWS_USED) rows_cfg = data;
      else cols_cfg = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes every weight and element a run could read that was never written,
   // stopping short of the triggering element.
   task automatic fill_region();
      int nr;
      int nc;
      nr = eff_count(rows_cfg);
      nc = eff_count(cols_cfg);
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++)
            if (!weight_set[r][c]) send_req(ACT_WEIGHT, IDX_W'(r), IDX_W'(c), pick_value());
      for (int c = 0; c < nc - 1; c++)
         if (!vector_set[c])
            send_req(ACT_VECTOR, IDX_W'($urandom_range(0, 63)), IDX_W'(c), pick_value());
   endtask

   task automatic random_phase(input logic [CNT_W-1:0] rcfg, input logic [CNT_W-1:0] ccfg,
                               input int count);
      int nr;
      int nc;
      int sel;
      int col;
      write_csr(CSR_ROWS_USED, rcfg);
      write_csr(CSR_COLS_USED, ccfg);
      nr = eff_count(rows_cfg);
      nc = eff_count(cols_cfg);
      fill_region();
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 38)
            send_req(ACT_WEIGHT, IDX_W'($urandom_range(0, nr - 1)),
                     IDX_W'($urandom_range(0, nc - 1)), pick_value());
         else if (sel < 50)
            send_req(ACT_WEIGHT, IDX_W'($urandom_range(0, 63)),
                     IDX_W'($urandom_range(0, 63)), pick_value());
         else begin
            col = (sel < 88) ? $urandom_range(0, nc - 1) : $urandom_range(0, 63);
            send_req(ACT_VECTOR, IDX_W'($urandom_range(0, 63)), IDX_W'(col), pick_value());
         end
      end
      send_req(ACT_VECTOR, IDX_W'($urandom_range(0, 63)), IDX_W'(nc - 1), pick_value());
   endtask

   always @(posedge clock) begin : check_results
      dot_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dots.size() == 0) begin
            $error("result with nothing pending: out_row %0d dot_sum %h", rsp_out_row,
                   rsp_dot_sum);
            fail_count++;
         end else begin
            exp_res = pending_dots.pop_front();
            if (rsp_out_row !== exp_res.row) begin
               $error("out_row: expected %0d, actual %0d", exp_res.row, rsp_out_row);
               fail_count++;
            end
            if (rsp_dot_sum !== exp_res.sum) begin
               $error("dot_sum: expected %h, actual %h", exp_res.sum, rsp_dot_sum);
               fail_count++;
            end
            if (rsp_last !== exp_res.last) begin
               $error("last: expected %0d, actual %0d", exp_res.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      // 1x1 extremes, an element past the used columns, saturation at 2 and 3 columns,
      // zero counts clamped to 1, then a 2-row run
      add_step(csr_step(CSR_ROWS_USED, 7'd1));
      add_step(csr_step(CSR_COLS_USED, 7'd1));
      add_step(req_step(ACT_WEIGHT, 6'd0, 6'd0, 16'h7FFF));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd0, 16'h7FFF, 1'b1, 32'h3FFF0001));
      add_step(req_step(ACT_WEIGHT, 6'd0, 6'd0, 16'h8000));
      add_step(req_step(ACT_VECTOR, 6'd63, 6'd0, 16'h8000, 1'b1, 32'h40000000));
      add_step(req_step(ACT_VECTOR, 6'd21, 6'd0, 16'h7FFF, 1'b1, 32'hC0008000));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd0, 16'h0000, 1'b1, 32'h00000000));
      add_step(req_step(ACT_VECTOR, 6'd42, 6'd5, 16'h1234));
      add_step(csr_step(CSR_COLS_USED, 7'd2));
      add_step(req_step(ACT_WEIGHT, 6'd0, 6'd1, 16'h8000));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd0, 16'h8000));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd1, 16'h8000, 1'b1, 32'h7FFFFFFF));
      add_step(csr_step(CSR_COLS_USED, 7'd3));
      add_step(req_step(ACT_WEIGHT, 6'd0, 6'd2, 16'h8000));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd0, 16'h7FFF));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd1, 16'h7FFF));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd2, 16'h7FFF, 1'b1, 32'h80000000));
      add_step(csr_step(CSR_ROWS_USED, 7'd0));
      add_step(csr_step(CSR_COLS_USED, 7'd0));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd0, 16'h0100, 1'b1, 32'hFF800000));
      add_step(csr_step(CSR_ROWS_USED, 7'd2));
      add_step(req_step(ACT_WEIGHT, 6'd1, 6'd0, 16'h0001));
      add_step(req_step(ACT_WEIGHT, 6'd63, 6'd63, 16'h7FFF));
      add_step(req_step(ACT_VECTOR, 6'd0, 6'd0, 16'hFFFF));

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == STEP_CSR)
            write_csr(directed[i].csr_idx, directed[i].csr_data);
         else
            send_req(directed[i].act, directed[i].row, directed[i].col, directed[i].val,
                     directed[i].typed, directed[i].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         no_idle = (p == 3 || p == 4);
         random_phase(PHASE_ROWS[p], PHASE_COLS[p], PHASE_ITEMS[p]);
      end
      no_idle = 1'b0;

      release_req();
      while (pending_dots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
